>>> rtl/arabic_contextual_shaper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Arabic contextual shaper
// Shared forms for next-cycle checks, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ARABIC_CONTEXTUAL_SHAPER_ASSERT_SVH
`define ARABIC_CONTEXTUAL_SHAPER_ASSERT_SVH

// Next-cycle implication that also holds while reset is applied.
`define ACS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("arabic_contextual_shaper: check failed");

// Next-cycle implication that is ignored while reset is applied.
`define ACS_ASSERT_RUN(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arabic_contextual_shaper: check failed");

`endif

>>> rtl/acs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Types, constants and the letter table of the Arabic contextual shaper.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int MAX_MARKS = 8;
  localparam int MARK_CW = $clog2(MAX_MARKS + 1);
  localparam int MARK_AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [20:0] CP_ZWNJ = 21'h00200C;
  localparam logic [20:0] CP_ZWJ = 21'h00200D;
  localparam logic [20:0] CP_LAM = 21'h000644;

  typedef struct packed {
    logic        hit;
    logic        jp;
    logic        jn;
    logic [15:0] fin;
    logic [15:0] ini;
    logic [15:0] med;
  } row_t;

  typedef struct packed {
    logic               a_valid;
    logic [20:0]        a_code;
    logic [MARK_CW-1:0] marks;
    logic               b_valid;
    logic [20:0]        b_code;
    logic               c_valid;
    logic [20:0]        c_code;
    logic               last;
    logic               overflow;
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic [MARK_AW-1:0] addr;
    logic [20:0]        data;
  } mark_wr_t;

  function automatic row_t mk_row(logic [15:0] fin, logic [15:0] ini, logic [15:0] med,
                                  logic jp, logic jn);
    row_t r;
    r.hit = 1'b1;
    r.jp = jp;
    r.jn = jn;
    r.fin = fin;
    r.ini = ini;
    r.med = med;
    return r;
  endfunction

  function automatic row_t lookup(logic [20:0] cp);
    row_t r;
    r = '0;
    case (cp)
      21'h000621: r = mk_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
      21'h000622: r = mk_row(16'hFE82, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000623: r = mk_row(16'hFE84, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000624: r = mk_row(16'hFE86, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000625: r = mk_row(16'hFE88, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000626: r = mk_row(16'hFE8A, 16'hFE8B, 16'hFE8C, 1'b1, 1'b1);
      21'h000627: r = mk_row(16'hFE8E, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000628: r = mk_row(16'hFE90, 16'hFE91, 16'hFE92, 1'b1, 1'b1);
      21'h000629: r = mk_row(16'hFE94, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h00062A: r = mk_row(16'hFE96, 16'hFE97, 16'hFE98, 1'b1, 1'b1);
      21'h00062B: r = mk_row(16'hFE9A, 16'hFE9B, 16'hFE9C, 1'b1, 1'b1);
      21'h00062C: r = mk_row(16'hFE9E, 16'hFE9F, 16'hFEA0, 1'b1, 1'b1);
      21'h00062D: r = mk_row(16'hFEA2, 16'hFEA3, 16'hFEA4, 1'b1, 1'b1);
      21'h00062E: r = mk_row(16'hFEA6, 16'hFEA7, 16'hFEA8, 1'b1, 1'b1);
      21'h00062F: r = mk_row(16'hFEAA, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000630: r = mk_row(16'hFEAC, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000631: r = mk_row(16'hFEAE, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000632: r = mk_row(16'hFEB0, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000633: r = mk_row(16'hFEB2, 16'hFEB3, 16'hFEB4, 1'b1, 1'b1);
      21'h000634: r = mk_row(16'hFEB6, 16'hFEB7, 16'hFEB8, 1'b1, 1'b1);
      21'h000635: r = mk_row(16'hFEBA, 16'hFEBB, 16'hFEBC, 1'b1, 1'b1);
      21'h000636: r = mk_row(16'hFEBE, 16'hFEBF, 16'hFEC0, 1'b1, 1'b1);
      21'h000637: r = mk_row(16'hFEC2, 16'hFEC3, 16'hFEC4, 1'b1, 1'b1);
      21'h000638: r = mk_row(16'hFEC6, 16'hFEC7, 16'hFEC8, 1'b1, 1'b1);
      21'h000639: r = mk_row(16'hFECA, 16'hFECB, 16'hFECC, 1'b1, 1'b1);
      21'h00063A: r = mk_row(16'hFECE, 16'hFECF, 16'hFED0, 1'b1, 1'b1);
      21'h000640: r = mk_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
      21'h000641: r = mk_row(16'hFED2, 16'hFED3, 16'hFED4, 1'b1, 1'b1);
      21'h000642: r = mk_row(16'hFED6, 16'hFED7, 16'hFED8, 1'b1, 1'b1);
      21'h000643: r = mk_row(16'hFEDA, 16'hFEDB, 16'hFEDC, 1'b1, 1'b1);
      21'h000644: r = mk_row(16'hFEDE, 16'hFEDF, 16'hFEE0, 1'b1, 1'b1);
      21'h000645: r = mk_row(16'hFEE2, 16'hFEE3, 16'hFEE4, 1'b1, 1'b1);
      21'h000646: r = mk_row(16'hFEE6, 16'hFEE7, 16'hFEE8, 1'b1, 1'b1);
      21'h000647: r = mk_row(16'hFEEA, 16'hFEEB, 16'hFEEC, 1'b1, 1'b1);
      21'h000648: r = mk_row(16'hFEEE, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h000649: r = mk_row(16'hFEF0, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h00064A: r = mk_row(16'hFEF2, 16'hFEF3, 16'hFEF4, 1'b1, 1'b1);
      21'h000671: r = mk_row(16'hFB51, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h00067E: r = mk_row(16'hFB57, 16'hFB58, 16'hFB59, 1'b1, 1'b1);
      21'h000686: r = mk_row(16'hFB7B, 16'hFB7C, 16'hFB7D, 1'b1, 1'b1);
      21'h000698: r = mk_row(16'hFB8B, 16'h0000, 16'h0000, 1'b1, 1'b0);
      21'h0006A9: r = mk_row(16'hFB8F, 16'hFB90, 16'hFB91, 1'b1, 1'b1);
      21'h0006AF: r = mk_row(16'hFB93, 16'hFB94, 16'hFB95, 1'b1, 1'b1);
      21'h0006CC: r = mk_row(16'hFBFD, 16'hFBFE, 16'hFBFF, 1'b1, 1'b1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_transparent(logic [20:0] cp);
    return (cp inside {[21'h000610 : 21'h00061A], [21'h00064B : 21'h00065F], 21'h000670,
                       [21'h0006D6 : 21'h0006ED], CP_ZWJ});
  endfunction

  function automatic logic [15:0] lam_alef(logic [20:0] alef, logic joined_before);
    logic [15:0] lig;
    case (alef)
      21'h000622: lig = joined_before ? 16'hFEF6 : 16'hFEF5;
      21'h000623: lig = joined_before ? 16'hFEF8 : 16'hFEF7;
      21'h000625: lig = joined_before ? 16'hFEFA : 16'hFEF9;
      21'h000627: lig = joined_before ? 16'hFEFC : 16'hFEFB;
      default: lig = 16'h0000;
    endcase
    return lig;
  endfunction

  function automatic logic [20:0] shape(logic [20:0] base, row_t row, logic joined_before,
                                        logic next_back);
    logic        after;
    logic [20:0] res;
    after = row.jn && next_back;
    res = base;
    if (joined_before && after && row.med != 16'h0000) begin
      res = {5'd0, row.med};
    end else if (joined_before && row.fin != 16'h0000) begin
      res = {5'd0, row.fin};
    end else if (after && row.ini != 16'h0000) begin
      res = {5'd0, row.ini};
    end
    return res;
  endfunction

endpackage

>>> rtl/acs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_front
// Accepts items, classifies them and keeps the joining context. An item that
// releases or passes a character gives one back-end emit command; marks go to mark memory.
// ----------------------------------------------------------------------------
module acs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [20:0]       code_point,
  input  logic              end_of_text,
  input  logic              q_full,
  output logic              push,
  output acs_pkg::cmd_t     cmd,
  output acs_pkg::mark_wr_t mark_wr,
  input  logic              mark_done
);

  logic [20:0]                 held_letter, held_letter_next;
  acs_pkg::row_t               held_row, held_row_next;
  logic                        held_valid, held_valid_next;
  logic                        held_joined_before, held_joined_before_next;
  logic                        prior_joins_forward, prior_joins_forward_next;
  logic [acs_pkg::MARK_CW-1:0] mark_count, mark_count_next;
  logic                        busy;

  logic          accept;
  logic          transparent;
  logic          consumed;
  logic          store_mark;
  logic [15:0]   lig;
  acs_pkg::row_t row;

  // A new mark may not overwrite the mark memory while a release still reads it.
  assign transparent = acs_pkg::is_transparent(code_point);
  assign item_stall = q_full || (busy && transparent);
  assign accept = item_valid && !item_stall;
  assign push = accept && (cmd.a_valid || cmd.b_valid || cmd.c_valid);

  always_comb begin
    row = acs_pkg::lookup(code_point);
    lig = acs_pkg::lam_alef(code_point, held_joined_before);
    cmd = '0;
    consumed = 1'b0;
    store_mark = 1'b0;
    held_letter_next = held_letter;
    held_row_next = held_row;
    held_valid_next = held_valid;
    held_joined_before_next = held_joined_before;
    prior_joins_forward_next = prior_joins_forward;
    mark_count_next = mark_count;

    if (transparent) begin
      if (held_valid) begin
        if (mark_count < acs_pkg::MARK_CW'(acs_pkg::MAX_MARKS)) begin
          store_mark = 1'b1;
          mark_count_next = mark_count + acs_pkg::MARK_CW'(1);
        end else begin
          cmd.a_valid = 1'b1;
          cmd.a_code = acs_pkg::shape(held_letter, held_row, held_joined_before, 1'b0);
          cmd.marks = mark_count;
          cmd.b_valid = 1'b1;
          cmd.b_code = code_point;
          cmd.overflow = 1'b1;
          held_valid_next = 1'b0;
          held_joined_before_next = 1'b0;
          mark_count_next = '0;
        end
      end else begin
        cmd.b_valid = 1'b1;
        cmd.b_code = code_point;
      end
    end else begin
      if (held_valid) begin
        if (held_letter == acs_pkg::CP_LAM && mark_count == '0 && lig != 16'h0000) begin
          cmd.a_valid = 1'b1;
          cmd.a_code = {5'd0, lig};
          held_valid_next = 1'b0;
          held_joined_before_next = 1'b0;
          prior_joins_forward_next = 1'b0;
          consumed = 1'b1;
        end else begin
          cmd.a_valid = 1'b1;
          cmd.a_code = acs_pkg::shape(held_letter, held_row, held_joined_before,
                                      row.hit && row.jp);
          cmd.marks = mark_count;
          held_valid_next = 1'b0;
          held_joined_before_next = 1'b0;
          mark_count_next = '0;
        end
      end
      if (!consumed) begin
        prior_joins_forward_next = row.hit && row.jn;
        if (row.hit) begin
          held_letter_next = code_point;
          held_row_next = row;
          held_valid_next = 1'b1;
          held_joined_before_next = prior_joins_forward && row.jp;
          mark_count_next = '0;
        end else begin
          cmd.b_valid = 1'b1;
          cmd.b_code = code_point;
        end
      end
    end

    if (end_of_text) begin
      if (held_valid_next) begin
        if (!cmd.a_valid) begin
          cmd.a_valid = 1'b1;
          cmd.a_code = acs_pkg::shape(held_letter_next, held_row_next,
                                      held_joined_before_next, 1'b0);
          cmd.marks = mark_count_next;
        end else begin
          cmd.c_valid = 1'b1;
          cmd.c_code = acs_pkg::shape(held_letter_next, held_row_next,
                                      held_joined_before_next, 1'b0);
        end
        held_valid_next = 1'b0;
        held_joined_before_next = 1'b0;
        mark_count_next = '0;
      end
      prior_joins_forward_next = 1'b0;
      cmd.last = 1'b1;
    end
  end

  always_comb begin
    mark_wr.en = accept && store_mark;
    mark_wr.addr = mark_count[acs_pkg::MARK_AW-1:0];
    mark_wr.data = code_point;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_joined_before <= 1'b0;
      prior_joins_forward <= 1'b0;
      mark_count <= '0;
      held_letter <= '0;
      busy <= 1'b0;
    end else begin
      if (accept) begin
        held_valid <= held_valid_next;
        held_joined_before <= held_joined_before_next;
        prior_joins_forward <= prior_joins_forward_next;
        mark_count <= mark_count_next;
        held_letter <= held_letter_next;
      end
      if (mark_done) begin
        busy <= 1'b0;
      end else if (push && cmd.marks != '0) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_row <= held_row_next;
    end
  end

endmodule

>>> rtl/acs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module acs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  acs_pkg::cmd_t push_cmd,
  input  logic          pop,
  output acs_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  acs_pkg::cmd_t                slots [acs_pkg::QUEUE_DEPTH];
  logic [acs_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [acs_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [acs_pkg::QUEUE_CW-1:0] count;
  logic                         do_push;
  logic                         do_pop;

  assign full = (count == acs_pkg::QUEUE_CW'(acs_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == acs_pkg::QUEUE_AW'(acs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + acs_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == acs_pkg::QUEUE_AW'(acs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + acs_pkg::QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + acs_pkg::QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - acs_pkg::QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/acs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_back
// Carries out emit commands: the released letter, its marks from the mark
// memory, the passed character and the end-of-text letter, held under result_stall.
// ----------------------------------------------------------------------------
module acs_back (
  input  logic              clk,
  input  logic              rst,
  input  acs_pkg::cmd_t     head,
  input  logic              q_empty,
  output logic              pop,
  input  acs_pkg::mark_wr_t mark_wr,
  output logic              mark_done,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [20:0]       shaped_point,
  output logic              last_out,
  output logic              mark_overflow
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_A         = 6'b000010,
    ST_MARK_WAIT = 6'b000100,
    ST_MARK      = 6'b001000,
    ST_B         = 6'b010000,
    ST_C         = 6'b100000
  } state_t;

  state_t                      state, state_next;
  acs_pkg::cmd_t               cur;
  logic [acs_pkg::MARK_AW-1:0] idx, idx_next;
  logic [20:0]                 mark_mem [acs_pkg::MAX_MARKS];
  logic [20:0]                 rd_data;

  logic        load_ok;
  logic        load;
  logic [20:0] load_code;
  logic        load_last;
  logic        finish;
  logic        final_mark;

  function automatic state_t after_marks(acs_pkg::cmd_t c);
    state_t s;
    if (c.b_valid) begin
      s = ST_B;
    end else if (c.c_valid) begin
      s = ST_C;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  function automatic state_t after_a(acs_pkg::cmd_t c);
    return (c.marks != '0) ? ST_MARK : after_marks(c);
  endfunction

  function automatic state_t first_state(acs_pkg::cmd_t c);
    state_t s;
    if (c.a_valid) begin
      s = ST_A;
    end else if (c.marks != '0) begin
      s = ST_MARK_WAIT;
    end else begin
      s = after_marks(c);
    end
    return s;
  endfunction

  assign load_ok = !result_valid || !result_stall;
  assign final_mark = ((acs_pkg::MARK_CW'(idx) + acs_pkg::MARK_CW'(1)) == cur.marks);

  always_comb begin
    state_next = state;
    idx_next = idx;
    pop = 1'b0;
    load = 1'b0;
    load_code = '0;
    load_last = 1'b0;
    finish = 1'b0;
    mark_done = 1'b0;
    case (state)
      ST_IDLE: begin
        finish = 1'b1;
      end
      ST_A: begin
        if (load_ok) begin
          load = 1'b1;
          load_code = cur.a_code;
          load_last = cur.last && cur.marks == '0 && !cur.b_valid && !cur.c_valid;
          if (after_a(cur) == ST_IDLE) begin
            finish = 1'b1;
          end else begin
            state_next = after_a(cur);
          end
        end
      end
      ST_MARK_WAIT: begin
        state_next = ST_MARK;
      end
      ST_MARK: begin
        if (load_ok) begin
          load = 1'b1;
          load_code = rd_data;
          load_last = cur.last && final_mark && !cur.b_valid && !cur.c_valid;
          if (final_mark) begin
            mark_done = 1'b1;
            if (after_marks(cur) == ST_IDLE) begin
              finish = 1'b1;
            end else begin
              state_next = after_marks(cur);
            end
          end else begin
            idx_next = idx + acs_pkg::MARK_AW'(1);
            state_next = ST_MARK_WAIT;
          end
        end
      end
      ST_B: begin
        if (load_ok) begin
          load = 1'b1;
          load_code = cur.b_code;
          load_last = cur.last && !cur.c_valid;
          if (cur.c_valid) begin
            state_next = ST_C;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_C: begin
        if (load_ok) begin
          load = 1'b1;
          load_code = cur.c_code;
          load_last = cur.last;
          finish = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (finish) begin
      if (!q_empty) begin
        pop = 1'b1;
        idx_next = '0;
        state_next = first_state(head);
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      shaped_point <= load_code;
      last_out <= load_last;
      mark_overflow <= cur.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_wr.en) begin
      mark_mem[mark_wr.addr] <= mark_wr.data;
    end
    rd_data <= mark_mem[idx];
  end

endmodule

>>> rtl/arabic_contextual_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arabic_contextual_shaper
// Streaming Arabic contextual shaping into presentation forms.
// ----------------------------------------------------------------------------
// Codepoints enter one item at a time and leave as shaped results in the same
// order. A letter from the table is held with the marks after it until the
// next non-transparent item, a mark beyond MAX_MARKS or the end of text arrives;
// then the front end queues one command and the back end emits its results in
// order, holding each while result_stall is high. Items are taken while the
// two-entry command queue has room, so new items enter while the back end still
// emits; each mark after the first waits in ST_MARK_WAIT, since the mark memory
// has a registered read port. While a release with marks is still being read out, a new mark item waits.
// ----------------------------------------------------------------------------
module arabic_contextual_shaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [20:0] code_point,
  input  logic        end_of_text,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [20:0] shaped_point,
  output logic        last_out,
  output logic        mark_overflow
);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  logic              mark_done;
  acs_pkg::cmd_t     cmd;
  acs_pkg::cmd_t     head;
  acs_pkg::mark_wr_t mark_wr;

  acs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .code_point  (code_point),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push),
    .cmd         (cmd),
    .mark_wr     (mark_wr),
    .mark_done   (mark_done)
  );

  acs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  acs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .mark_wr       (mark_wr),
    .mark_done     (mark_done),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .shaped_point  (shaped_point),
    .last_out      (last_out),
    .mark_overflow (mark_overflow)
  );

endmodule

>>> rtl/acs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks of the Arabic contextual shaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "arabic_contextual_shaper_assert.svh"

module acs_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [20:0] shaped_point,
  input logic        last_out,
  input logic        mark_overflow
);

  logic [22:0] result_word;

  assign result_word = {shaped_point, last_out, mark_overflow};

  `ACS_ASSERT_NEXT(a_reset_clears_result, rst, !result_valid)
  `ACS_ASSERT_NEXT(a_reset_frees_input, rst, !item_stall)
  `ACS_ASSERT_RUN(a_result_held, result_valid && result_stall, result_valid)
  `ACS_ASSERT_RUN(a_result_stable, result_valid && result_stall, $stable(result_word))

endmodule

bind arabic_contextual_shaper acs_checker u_acs_checker (
  .clk           (clk),
  .rst           (rst),
  .item_stall    (item_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .shaped_point  (shaped_point),
  .last_out      (last_out),
  .mark_overflow (mark_overflow)
);
